FILE: rtl/timestamp_mapping_table_assert.svh
// Assertion macros for the timestamp mapping table checker.
`ifndef TIMESTAMP_MAPPING_TABLE_ASSERT_SVH
`define TIMESTAMP_MAPPING_TABLE_ASSERT_SVH
// Implication checked at each clock edge outside reset.
`define TMT_ASSERT_IMP(label, clk, rst_n, a, c) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
	else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define TMT_ASSERT_NXT(label, clk, rst_n, a, c) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
	else $error("assertion failed");
`endif

FILE: rtl/tmt_pkg.sv
// Shared types and constants of the timestamp mapping table.
package tmt_pkg;
	localparam logic [1:0] MODE_ADD     = 2'd0;
	localparam logic [1:0] MODE_LOOKUP  = 2'd1;
	localparam logic [1:0] MODE_CLEANUP = 2'd2;
	localparam logic [1:0] MODE_PLAYOUT = 2'd3;
	localparam logic [15:0] TOL_RESET   = 16'd100;
	localparam logic [19:0] US_PER_S    = 20'd1000000;

	// one stored mapping
	typedef struct packed {
		logic        vld;
		logic [31:0] its;
		logic [31:0] ots;
		logic [47:0] arr;
	} entry_t;

	// per-cycle command broadcast along the row
	typedef struct packed {
		logic        shift;    // shift toward slot 0 by one
		logic        load;     // write new entry into first free slot
		logic        compact;  // one compaction step
		logic [47:0] cutoff;
		logic [31:0] its;
		logic [31:0] ots;
		logic [47:0] arr;
	} cmd_t;
endpackage

FILE: rtl/tmt_cell.sv
// One slot of the mapping row: holds an entry and hands it to its lower neighbor.
module tmt_cell (
	input  logic             clk,
	input  logic             arst_n,
	input  tmt_pkg::cmd_t    cmd,
	input  tmt_pkg::entry_t  upper,     // neighbor above (newer)
	input  logic             lower_vld, // neighbor below valid
	input  logic             drop_below,// some cell below drops this step
	output tmt_pkg::entry_t  ent,
	output logic             drop       // this cell is stale in compaction
);
	tmt_pkg::entry_t ent_q;
	assign ent = ent_q;
	assign drop = ent_q.vld && (ent_q.arr < cmd.cutoff);

	// advance the row: full shift, load at first free, or compaction step
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ent_q.vld <= 1'b0;
		end else if (cmd.shift || (cmd.compact && (drop_below || drop))) begin
			ent_q <= upper;
		end else if (cmd.load && !ent_q.vld && lower_vld) begin
			ent_q <= '{vld: 1'b1, its: cmd.its, ots: cmd.ots, arr: cmd.arr};
		end
	end
endmodule

FILE: rtl/tmt_divider.sv
// Restoring divider for the running latency average, one quotient bit per cycle.
module tmt_divider (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [55:0] dividend,
	input  logic [32:0] divisor,
	output logic        done,
	output logic [23:0] quotient
);
	logic [55:0] q_q;
	logic [33:0] r_q;
	logic [5:0]  cnt_q;
	logic        busy_q;
	logic [33:0] trial;
	assign trial = {r_q[32:0], q_q[55]} - {1'b0, divisor};

	// shift in one dividend bit and subtract when it fits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done   <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				q_q    <= dividend;
				r_q    <= '0;
				cnt_q  <= 6'd55;
			end else if (busy_q) begin
				if (trial[33]) r_q <= {r_q[32:0], q_q[55]};
				else           r_q <= trial;
				q_q <= {q_q[54:0], ~trial[33]};
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end
	assign quotient = q_q[23:0];
endmodule

FILE: rtl/timestamp_mapping_table.sv
// Top level of the timestamp mapping table.
// Each beat takes one mode and returns one result beat. The table is a row of
// DEPTH cells, slot 0 oldest. Add waits for the 56-step average divider (the
// first sample needs no divide); lookup reads one cell at a time from the
// newest slot; cleanup removes one stale entry per cycle; playout goes
// straight to the output state. The result sits in an output register, and
// the next beat is taken only once it has been handed off.
module timestamp_mapping_table #(
	parameter int DEPTH = 64
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [15:0]  cfg_data,      // match_tolerance
	input  logic         s_tvalid,
	output logic         s_tready,
	// mode[1:0], input_timestamp[33:2], output_timestamp[65:34], time_us[113:66],
	// latency_us[137:114], jitter_delay_us[161:138], max_age_s[177:162], pad
	input  logic [183:0] s_tdata,
	output logic         m_tvalid,
	input  logic         m_tready,
	// found[0], mapped_timestamp[32:1], playout_time_us[80:33], entries_held[87:81],
	// avg[111:88], min[135:112], max[159:136], samples_seen[191:160]
	output logic [191:0] m_tdata
);
	localparam int IW = $clog2(DEPTH + 1);

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001, ST_DIV = 5'b00010, ST_LOOK = 5'b00100,
		ST_CLEAN = 5'b01000, ST_OUT = 5'b10000
	} st_t;
	st_t st_q;

	logic [183:0] in_q;
	logic [15:0]  tol_q;
	logic [23:0]  avg_q, min_q, max_q;
	logic [31:0]  n_q;
	logic [IW-1:0] held_q, idx_q;
	logic         found_q;
	logic [31:0]  mapped_q;
	logic [47:0]  play_q;
	logic         mvalid_q;
	logic [31:0]  look_its_q, look_ots_q;
	logic         phase_q;
	logic         div_start_pending;

	wire [1:0]  i_mode = in_q[1:0];
	wire [31:0] i_its  = in_q[33:2];
	wire [47:0] i_time = in_q[113:66];
	wire [23:0] i_lat  = in_q[137:114];
	wire [23:0] i_jit  = in_q[161:138];
	wire [15:0] i_age  = in_q[177:162];

	tmt_pkg::cmd_t   cmd;
	tmt_pkg::entry_t ents [DEPTH+1];
	logic            drops [DEPTH];
	logic            dbel  [DEPTH+1];

	assign ents[DEPTH]  = '0;
	assign dbel[0]      = 1'b0;

	// row of cells
	for (genvar g = 0; g < DEPTH; g++) begin : g_cell
		assign dbel[g+1] = dbel[g] | drops[g];
		tmt_cell u_cell (
			.clk(clk), .arst_n(arst_n), .cmd(cmd), .upper(ents[g+1]),
			.lower_vld((g == 0) ? 1'b1 : ents[(g == 0) ? 0 : g-1].vld),
			.drop_below(dbel[g]), .ent(ents[g]), .drop(drops[g])
		);
	end

	// cutoff, saturated at zero
	logic [35:0] age_us;
	logic [47:0] cutoff;
	assign age_us = i_age * tmt_pkg::US_PER_S;
	assign cutoff = (i_time < {12'd0, age_us}) ? 48'd0 : i_time - {12'd0, age_us};

	// lookup compare on the cell read in the previous cycle
	logic [IW-1:0] li;
	logic [31:0]   dd, mag;
	assign li  = idx_q - IW'(1);
	assign dd  = i_its - look_its_q;
	assign mag = (dd > 32'h8000_0000) ? (32'd0 - dd) : dd;

	// divider for the average
	logic        div_start, div_done;
	logic [23:0] div_q;
	tmt_divider u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start),
		.dividend(avg_q * n_q + {32'd0, i_lat}),
		.divisor({1'b0, n_q} + 33'd1), .done(div_done), .quotient(div_q)
	);

	logic full;
	assign full = (held_q == IW'(DEPTH));

	// row command: compact during cleanup; for add, shift and divider start first, load the new entry at the end
	always_comb begin
		cmd         = '0;
		cmd.its     = i_its;
		cmd.ots     = in_q[65:34];
		cmd.arr     = i_time;
		cmd.cutoff  = cutoff;
		div_start   = 1'b0;
		if (st_q == ST_CLEAN) cmd.compact = 1'b1;
		if (div_start_pending) begin
			cmd.shift = full;
			div_start = (n_q != '0);
		end
		if (st_q == ST_DIV && phase_q && (n_q == '0 || div_done)) cmd.load = 1'b1;
	end

	assign s_tready  = (st_q == ST_IDLE) && !mvalid_q;
	assign cfg_ready = 1'b1;
	assign m_tvalid  = mvalid_q;
	assign m_tdata   = {n_q, max_q, min_q, avg_q, 7'(held_q), play_q, mapped_q, found_q};

	// sequencer
	assign div_start_pending = (st_q == ST_DIV) && !phase_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE; tol_q <= tmt_pkg::TOL_RESET; mvalid_q <= 1'b0;
			avg_q <= '0; min_q <= '0; max_q <= '0; n_q <= '0; held_q <= '0;
			idx_q <= '0; phase_q <= 1'b0; found_q <= 1'b0; mapped_q <= '0; play_q <= '0;
			look_its_q <= '0; look_ots_q <= '0;
		end else begin
			if (cfg_valid) tol_q <= cfg_data;
			if (mvalid_q && m_tready) mvalid_q <= 1'b0;
			case (st_q)
				ST_IDLE: if (s_tvalid && s_tready) begin
					in_q <= s_tdata;
					found_q <= 1'b0; mapped_q <= '0; play_q <= '0; phase_q <= 1'b0;
					case (s_tdata[1:0])
						tmt_pkg::MODE_ADD:    st_q <= ST_DIV;
						tmt_pkg::MODE_LOOKUP: begin st_q <= ST_LOOK; idx_q <= held_q; end
						tmt_pkg::MODE_CLEANUP: st_q <= ST_CLEAN;
						default: st_q <= ST_OUT;
					endcase
				end
				ST_DIV: begin
					if (!phase_q) begin
						phase_q <= 1'b1;
						if (full) held_q <= held_q - IW'(1);
					end else if (n_q == '0) begin
						avg_q <= i_lat; min_q <= i_lat; max_q <= i_lat;
						n_q <= 32'd1; held_q <= held_q + IW'(1); st_q <= ST_OUT;
					end else if (div_done) begin
						avg_q <= div_q;
						if (i_lat < min_q) min_q <= i_lat;
						if (i_lat > max_q) max_q <= i_lat;
						if (n_q != 32'hFFFF_FFFF) n_q <= n_q + 32'd1;
						held_q <= held_q + IW'(1); st_q <= ST_OUT;
					end
				end
				ST_LOOK: begin
					if (idx_q == '0) st_q <= ST_OUT;
					else if (!phase_q) begin
						look_its_q <= ents[li[$clog2(DEPTH)-1:0]].its;
						look_ots_q <= ents[li[$clog2(DEPTH)-1:0]].ots;
						phase_q <= 1'b1;
					end else begin
						phase_q <= 1'b0;
						if (mag == 32'd0 || mag < {16'd0, tol_q}) begin
							found_q <= 1'b1; mapped_q <= look_ots_q;
							st_q <= ST_OUT;
						end else idx_q <= li;
					end
				end
				// one stale entry leaves the row per cycle
				ST_CLEAN: begin
					if (dbel[DEPTH]) held_q <= held_q - IW'(1);
					else st_q <= ST_OUT;
				end
				ST_OUT: begin
					if (i_mode == tmt_pkg::MODE_PLAYOUT)
						play_q <= i_time + {24'd0, i_jit} + {24'd0, avg_q};
					mvalid_q <= 1'b1; st_q <= ST_IDLE;
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end
endmodule

FILE: rtl/tmt_checker.sv
// Port-level checker for the timestamp mapping table, bound to the top level.
`include "timestamp_mapping_table_assert.svh"
module tmt_checker (
	input logic         clk,
	input logic         arst_n,
	input logic         s_tvalid,
	input logic         s_tready,
	input logic         m_tvalid,
	input logic         m_tready,
	input logic [191:0] m_tdata
);
	`TMT_ASSERT_IMP(a_no_take_while_out, clk, arst_n, m_tvalid, !s_tready)
	`TMT_ASSERT_NXT(a_one_in_flight, clk, arst_n, s_tvalid && s_tready, !s_tready)
	`TMT_ASSERT_NXT(a_out_holds, clk, arst_n, m_tvalid && !m_tready, $stable(m_tdata))
	`TMT_ASSERT_IMP(a_held_range, clk, arst_n, m_tvalid, m_tdata[87:81] <= 7'd64)
	`TMT_ASSERT_IMP(a_found_map, clk, arst_n, m_tvalid && !m_tdata[0], m_tdata[32:1] == 32'd0)
endmodule

bind timestamp_mapping_table tmt_checker u_tmt_checker (
	.clk(clk), .arst_n(arst_n), .s_tvalid(s_tvalid), .s_tready(s_tready),
	.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
);

FILE: tb/tb.sv
// Self-checking testbench for the timestamp mapping table: directed table, then random phases.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int SLOTS = 64;
	localparam int IDLE_LIMIT = 3000;
	localparam int SETTLE = 100;
	localparam int LONG_HOLD = 400;
	localparam int N_DIR = 14;
	localparam int EXP_DEPTH = 16;

	// input beat, first field in the low bits
	typedef struct packed {
		logic [5:0]  pad;
		logic [15:0] age_s;
		logic [23:0] jit;
		logic [23:0] lat;
		logic [47:0] t_us;
		logic [31:0] ots;
		logic [31:0] its;
		logic [1:0]  mode;
	} beat_t;

	// result beat, first field in the low bits
	typedef struct packed {
		logic [31:0] samples;
		logic [23:0] lat_max;
		logic [23:0] lat_min;
		logic [23:0] lat_avg;
		logic [6:0]  held;
		logic [47:0] playout;
		logic [31:0] mapped;
		logic        found;
	} result_t;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         cfg_valid = 1'b0;
	logic         cfg_ready;
	logic [15:0]  cfg_data = '0;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	logic [183:0] s_tdata = '0;
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	logic [191:0] m_tdata;

	timestamp_mapping_table #(.DEPTH(SLOTS)) dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	always #6 clk = ~clk;

	// mirror of the table and statistics
	logic [31:0] tbl_its [SLOTS];
	logic [31:0] tbl_ots [SLOTS];
	logic [47:0] tbl_arr [SLOTS];
	int          tbl_held = 0;
	logic [23:0] st_avg = '0, st_min = '0, st_max = '0;
	logic [31:0] st_samples = '0;
	logic [15:0] tolerance = tmt_pkg::TOL_RESET;

	// expected results, written by the sender and read by the monitor
	result_t     exp_fifo [EXP_DEPTH];
	int          exp_wr = 0;
	int          exp_rd = 0;
	int          errors = 0;
	int          burst_left = 0;
	bit          long_hold_req = 0;
	logic [47:0] now_us = 48'd5000000;

	// apply one beat to the mirror and return the result it yields
	function automatic result_t mirror_step(beat_t b);
		result_t r;
		logic [31:0] d, mag;
		logic [63:0] age_us, sum;
		logic [47:0] cutoff;
		int w;
		r = '0;
		case (b.mode)
			tmt_pkg::MODE_ADD: begin
				if (tbl_held >= SLOTS) begin
					for (int i = 1; i < SLOTS; i++) begin
						tbl_its[i-1] = tbl_its[i];
						tbl_ots[i-1] = tbl_ots[i];
						tbl_arr[i-1] = tbl_arr[i];
					end
					tbl_held = SLOTS - 1;
				end
				tbl_its[tbl_held] = b.its;
				tbl_ots[tbl_held] = b.ots;
				tbl_arr[tbl_held] = b.t_us;
				tbl_held++;
				if (st_samples == 0) begin
					st_avg = b.lat;
					st_min = b.lat;
					st_max = b.lat;
				end else begin
					sum = 64'(st_avg) * 64'(st_samples) + 64'(b.lat);
					st_avg = 24'(sum / (64'(st_samples) + 64'd1));
					if (b.lat < st_min) st_min = b.lat;
					if (b.lat > st_max) st_max = b.lat;
				end
				if (st_samples != 32'hFFFF_FFFF) st_samples++;
			end
			tmt_pkg::MODE_LOOKUP: begin
				for (int i = tbl_held - 1; i >= 0 && !r.found; i--) begin
					d = b.its - tbl_its[i];
					mag = (d > 32'h8000_0000) ? (32'h0 - d) : d;
					if (mag == 0 || 33'(mag) < 33'(tolerance)) begin
						r.found = 1'b1;
						r.mapped = tbl_ots[i];
					end
				end
			end
			tmt_pkg::MODE_CLEANUP: begin
				age_us = 64'(b.age_s) * 64'(tmt_pkg::US_PER_S);
				if (64'(b.t_us) >= age_us) begin
					cutoff = 48'(64'(b.t_us) - age_us);
					w = 0;
					for (int i = 0; i < tbl_held; i++) begin
						if (tbl_arr[i] >= cutoff) begin
							tbl_its[w] = tbl_its[i];
							tbl_ots[w] = tbl_ots[i];
							tbl_arr[w] = tbl_arr[i];
							w++;
						end
					end
					tbl_held = w;
				end
			end
			default: r.playout = b.t_us + 48'(b.jit) + 48'(st_avg);
		endcase
		r.held = 7'(tbl_held);
		r.lat_avg = st_avg;
		r.lat_min = st_min;
		r.lat_max = st_max;
		r.samples = st_samples;
		return r;
	endfunction

	function automatic beat_t mk_beat(logic [1:0] mode, logic [31:0] its, logic [31:0] ots,
			logic [47:0] t_us, logic [23:0] lat, logic [23:0] jit, logic [15:0] age_s);
		beat_t b;
		b = '{pad: '0, age_s: age_s, jit: jit, lat: lat, t_us: t_us, ots: ots, its: its,
			mode: mode};
		return b;
	endfunction

	function automatic result_t mk_stats(logic [6:0] held, logic [23:0] avg, logic [23:0] mn,
			logic [23:0] mx, logic [31:0] n);
		result_t r;
		r = '0;
		r.held = held;
		r.lat_avg = avg;
		r.lat_min = mn;
		r.lat_max = mx;
		r.samples = n;
		return r;
	endfunction

	// offer one beat in the current burst, record its expected result on acceptance
	task automatic send_beat(beat_t b, bit fixed, result_t fixed_res);
		result_t r;
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			burst_left = $urandom_range(1, 16);
		end
		s_tdata <= b;
		s_tvalid <= 1'b1;
		do @(posedge clk); while (!s_tready);
		r = mirror_step(b);
		exp_fifo[exp_wr % EXP_DEPTH] = fixed ? fixed_res : r;
		exp_wr++;
		burst_left--;
		@(negedge clk);
	endtask

	// write the tolerance register while the block is idle
	task automatic write_tolerance(logic [15:0] value);
		cfg_data <= value;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		tolerance = value;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		burst_left = 0;
		while (exp_rd != exp_wr) @(negedge clk);
		repeat (SETTLE) @(posedge clk);
		@(negedge clk);
	endtask

	// random beat, mostly well-formed traffic around the stored mappings
	function automatic beat_t rand_beat(int add_pct);
		beat_t b;
		int pick, span;
		b = mk_beat(2'($urandom_range(0, 3)), $urandom, $urandom, now_us,
			24'($urandom_range(0, 8000)), 24'($urandom), 16'($urandom_range(0, 3)));
		pick = $urandom_range(0, 99);
		if (pick < add_pct) begin
			b.mode = tmt_pkg::MODE_ADD;
			now_us += 48'($urandom_range(1, 400000));
			b.t_us = now_us;
			if ($urandom_range(0, 15) == 0) b.lat = 24'($urandom);
		end else if (pick < add_pct + (100 - add_pct) / 2) begin
			b.mode = tmt_pkg::MODE_LOOKUP;
			if (tbl_held > 0 && $urandom_range(0, 4) != 0) begin
				span = int'(tolerance) + 2;
				b.its = tbl_its[$urandom_range(0, tbl_held - 1)]
					+ 32'($urandom_range(0, 2 * span)) - 32'(span);
			end
		end else if ($urandom_range(0, 2) == 0) begin
			b.mode = tmt_pkg::MODE_CLEANUP;
			if ($urandom_range(0, 9) == 0) b.age_s = 16'($urandom);
		end else begin
			b.mode = tmt_pkg::MODE_PLAYOUT;
			if ($urandom_range(0, 3) == 0) b.t_us = 48'({$urandom, $urandom});
		end
		return b;
	endfunction

	// compare each result beat with the oldest expectation
	always @(posedge clk) begin
		result_t got, want;
		if (arst_n && m_tvalid && m_tready) begin
			got = m_tdata;
			if (exp_rd == exp_wr) begin
				$display("%0t: unexpected result beat %h", $realtime, got);
				errors++;
			end else begin
				want = exp_fifo[exp_rd % EXP_DEPTH];
				exp_rd++;
				if (got.found !== want.found)
					$display("%0t: found exp %h got %h", $realtime, want.found, got.found);
				if (got.mapped !== want.mapped)
					$display("%0t: mapped exp %h got %h", $realtime, want.mapped, got.mapped);
				if (got.playout !== want.playout)
					$display("%0t: playout exp %h got %h", $realtime, want.playout, got.playout);
				if (got.held !== want.held)
					$display("%0t: held exp %0d got %0d", $realtime, want.held, got.held);
				if (got.lat_avg !== want.lat_avg)
					$display("%0t: avg exp %h got %h", $realtime, want.lat_avg, got.lat_avg);
				if (got.lat_min !== want.lat_min)
					$display("%0t: min exp %h got %h", $realtime, want.lat_min, got.lat_min);
				if (got.lat_max !== want.lat_max)
					$display("%0t: max exp %h got %h", $realtime, want.lat_max, got.lat_max);
				if (got.samples !== want.samples)
					$display("%0t: samples exp %h got %h", $realtime, want.samples, got.samples);
				if (got !== want) errors++;
			end
		end
	end

	// stall the result side: random spells, free-running spells, one long hold
	initial begin
		int spell;
		forever begin
			@(negedge clk);
			if (long_hold_req) begin
				m_tready <= 1'b0;
				repeat (LONG_HOLD) @(negedge clk);
				long_hold_req = 0;
			end
			spell = $urandom_range(0, 2);
			repeat ($urandom_range(8, 48)) begin
				m_tready <= (spell == 0) ? 1'b1 : ($urandom_range(0, spell) == 0);
				@(negedge clk);
			end
		end
	end

	// end the run when nothing moves for too long
	initial begin
		int idle;
		idle = 0;
		forever begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
				idle = 0;
			else
				idle++;
			if (idle >= IDLE_LIMIT) begin
				$display("%0t: no progress for %0d cycles", $realtime, idle);
				$display("Verification failed");
				$finish;
			end
		end
	end

	beat_t   dir_beat [N_DIR];
	bit      dir_fixed [N_DIR];
	result_t dir_res [N_DIR];
	logic [15:0] tol_plan [4];

	initial begin
		// directed rows: extremes, wrap, early cleanup, full wipe
		dir_beat[0]  = mk_beat(tmt_pkg::MODE_PLAYOUT, '0, '0, '0, '0, '0, '0);
		dir_beat[1]  = mk_beat(tmt_pkg::MODE_LOOKUP, '0, '0, '0, '0, '0, '0);
		dir_beat[2]  = mk_beat(tmt_pkg::MODE_ADD, 32'h0, 32'hFFFF_FFFF, 48'd1000,
			24'hFF_FFFF, '0, '0);
		dir_beat[3]  = mk_beat(tmt_pkg::MODE_ADD, 32'hFFFF_FFFF, 32'h1, 48'd2000, 24'h0,
			'0, '0);
		dir_beat[4]  = mk_beat(tmt_pkg::MODE_LOOKUP, 32'h5, '0, '0, '0, '0, '0);
		dir_beat[5]  = mk_beat(tmt_pkg::MODE_LOOKUP, 32'h8000_0000, '0, '0, '0, '0, '0);
		dir_beat[6]  = mk_beat(tmt_pkg::MODE_LOOKUP, 32'h63, '0, '0, '0, '0, '0);
		dir_beat[7]  = mk_beat(tmt_pkg::MODE_PLAYOUT, '0, '0, 48'hFFFF_FFFF_FFFF, '0,
			24'hFF_FFFF, '0);
		dir_beat[8]  = mk_beat(tmt_pkg::MODE_CLEANUP, '0, '0, 48'd0, '0, '0, 16'hFFFF);
		dir_beat[9]  = mk_beat(tmt_pkg::MODE_CLEANUP, '0, '0, 48'd1500, '0, '0, 16'h0);
		dir_beat[10] = mk_beat(tmt_pkg::MODE_CLEANUP, '0, '0, 48'hFFFF_FFFF_FFFF, '0, '0,
			16'hFFFF);
		dir_beat[11] = mk_beat(tmt_pkg::MODE_ADD, 32'hA5A5_5A5A, 32'h5A5A_A5A5,
			48'hFFFF_FFFF_FFFF, 24'h00_0001, '0, '0);
		dir_beat[12] = mk_beat(tmt_pkg::MODE_LOOKUP, 32'hA5A5_5A5A, '0, '0, '0, '0, '0);
		dir_beat[13] = mk_beat(tmt_pkg::MODE_PLAYOUT, '0, '0, 48'h1234_5678_9ABC, '0,
			24'h80_0000, '0);
		foreach (dir_fixed[i]) dir_fixed[i] = 0;
		foreach (dir_res[i]) dir_res[i] = '0;
		dir_fixed[0] = 1;
		dir_fixed[1] = 1;
		dir_fixed[2] = 1;
		dir_res[2] = mk_stats(7'd1, 24'hFF_FFFF, 24'hFF_FFFF, 24'hFF_FFFF, 32'd1);
		dir_fixed[3] = 1;
		dir_res[3] = mk_stats(7'd2, 24'h7F_FFFF, 24'h0, 24'hFF_FFFF, 32'd2);
		dir_fixed[10] = 1;
		dir_res[10] = mk_stats(7'd0, 24'h7F_FFFF, 24'h0, 24'hFF_FFFF, 32'd2);
		tol_plan[0] = 16'd0;
		tol_plan[1] = 16'hFFFF;
		tol_plan[2] = 16'($urandom_range(1, 5000));
		tol_plan[3] = tmt_pkg::TOL_RESET;

		// hold reset, then release on a falling edge
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		for (int i = 0; i < N_DIR; i++) send_beat(dir_beat[i], dir_fixed[i], dir_res[i]);
		drain();

		// random phases, one tolerance each; the second fills past the table size
		for (int p = 0; p < 4; p++) begin
			write_tolerance(tol_plan[p]);
			if (p == 2) long_hold_req = 1;
			repeat (100) send_beat(rand_beat(p == 1 ? 85 : 40), 0, '0);
			drain();
		end

		if (errors == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end
endmodule

FILE: files.f
+incdir+rtl
rtl/tmt_pkg.sv
rtl/tmt_cell.sv
rtl/tmt_divider.sv
rtl/timestamp_mapping_table.sv
rtl/tmt_checker.sv
tb/tb.sv
